/* src/zced_pkg.sv */
// Shared constants and types for the zero crossing edge detector.
// No dependencies; every other source file imports this package.
package zced_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;

    localparam int CH_W       = 9;                        // one color channel
    localparam int SUM_W      = 11;                       // r+g+b, -768..765
    localparam int THR_W      = 9;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 11;                       // clamped width or height
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int PEND_W     = $clog2(MAX_COLS + 3);
    localparam int POS_W      = 10;                       // out_row / out_col fields
    localparam int EDGE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [DIM_W-1:0]      DIM_MIN    = 11'd3;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [CH_W-1:0]  t_chan;

endpackage

/* src/zced_in_if.sv */
// Pixel request channel: valid/ready handshake plus the pixel payload.
// Depends on zced_pkg.
interface zced_in_if import zced_pkg::*; ;
    logic  valid;
    logic  ready;
    logic  req_type;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, req_type, red, green, blue, input ready);
    modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

/* src/zced_out_if.sv */
// Edge result channel: valid/ready handshake plus the result payload.
// Depends on zced_pkg.
interface zced_out_if import zced_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] edge_value;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              frame_last;

    modport source (output valid, edge_value, out_row, out_col, frame_last, input ready);
    modport sink   (input valid, edge_value, out_row, out_col, frame_last, output ready);
endinterface

/* src/zero_crossing_edge_detector.sv */
// Zero crossing edge detector top level: position tracking, line buffer,
// 3x3 sum window and result register. Depends on zced_pkg, zced_in_if, zced_out_if.
//
// Streams one RGB request per clock in raster order and answers each centre
// pixel with 255 (zero crossing) or 0. The pixel sum r+g+b goes into a
// 1024 x 22 line buffer (the two previous rows side by side at the column
// address) and a 3x3 window of sums. A centre gives 255 only if it is off
// the border, its sum is at least 3*threshold, and some opposite pair of
// neighbours (vertical, horizontal, either diagonal) has a product <= 0.
// Results trail their pixel by cols+1 requests; after the last pixel of a
// frame send cols+1 flush requests to push the rest out. Throughput is one
// request per clock; a request that releases a result is held in stage B,
// and the result is registered from there. The input stalls only while a
// releasing request waits behind a full result register that the receiver
// is not taking. The line buffer is read once at acceptance and written
// once in the following stage, with a bypass for back-to-back same-column
// access. Unwritten line buffer entries only feed border results, so there
// is no clearing pass after reset. Configuration writes are only legal
// while the block is idle.
module zero_crossing_edge_detector import zced_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    zced_in_if.sink               i_in,
    zced_out_if.source            o_out
);

    // opposite pair crosses zero: product <= 0
    function automatic logic crosses(input t_sum a, input t_sum b);
        return (a == '0) || (b == '0) || (a[SUM_W-1] != b[SUM_W-1]);
    endfunction

    // ---------------- configuration ----------------
    logic signed [THR_W-1:0] r_thr;
    logic [CFG_DATA_W-1:0]   r_width;
    logic [CFG_DATA_W-1:0]   r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:    r_thr    <= i_cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] cols, rows;
    assign cols = (r_width < DIM_MIN) ? DIM_MIN :
                  (r_width > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_width;
    assign rows = (r_height < DIM_MIN) ? DIM_MIN :
                  (r_height > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_height;

    // ---------------- position / pending tracking ----------------
    logic [COL_W-1:0]  r_in_col, r_o_col;
    logic [ROW_W-1:0]  r_in_row, r_o_row;
    logic [PEND_W-1:0] r_pend;

    logic [COL_W-1:0]  in_col_e, o_col_e, n_in_col, n_o_col;
    logic [ROW_W-1:0]  in_row_e, o_row_e, n_in_row, n_o_row;
    logic [PEND_W-1:0] n_pend, pend_inc;
    logic              is_pix, emit, border, last;
    t_sum              sum_in;

    // stage B (line buffer data valid) control and payload
    logic              r_b_valid, r_b_pix, r_b_emit, r_b_border, r_b_last;
    logic [COL_W-1:0]  r_b_addr, r_b_col;
    logic [ROW_W-1:0]  r_b_row;
    t_sum              r_b_sum;
    logic              r_out_valid;
    logic              b_go, in_fire;

    assign b_go    = r_b_valid && (!r_b_emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_b_valid || b_go;
    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        is_pix = (i_in.req_type == REQ_PIXEL);
        sum_in = t_sum'({{(SUM_W-CH_W){i_in.red[CH_W-1]}},   i_in.red})
               + t_sum'({{(SUM_W-CH_W){i_in.green[CH_W-1]}}, i_in.green})
               + t_sum'({{(SUM_W-CH_W){i_in.blue[CH_W-1]}},  i_in.blue});

        // stale positions after a size change restart at zero
        in_col_e = (DIM_W'(r_in_col) >= cols) ? '0 : r_in_col;
        in_row_e = (DIM_W'(r_in_row) >= rows) ? '0 : r_in_row;
        o_col_e  = (DIM_W'(r_o_col)  >= cols) ? '0 : r_o_col;
        o_row_e  = (DIM_W'(r_o_row)  >= rows) ? '0 : r_o_row;

        n_in_col = in_col_e;
        n_in_row = in_row_e;
        n_o_col  = o_col_e;
        n_o_row  = o_row_e;
        pend_inc = r_pend + PEND_W'(1);

        if (is_pix) begin
            if (DIM_W'(in_col_e) + DIM_W'(1) >= cols) begin
                n_in_col = '0;
                n_in_row = (DIM_W'(in_row_e) + DIM_W'(1) >= rows) ? '0
                                                                   : in_row_e + ROW_W'(1);
            end else begin
                n_in_col = in_col_e + COL_W'(1);
            end
            emit   = pend_inc > (PEND_W'(cols) + PEND_W'(1));
            n_pend = emit ? r_pend : pend_inc;
        end else begin
            emit   = (r_pend != '0);
            n_pend = emit ? r_pend - PEND_W'(1) : r_pend;
        end

        border = (o_row_e == '0) || (o_col_e == '0)
              || (DIM_W'(o_row_e) == rows - DIM_W'(1))
              || (DIM_W'(o_col_e) == cols - DIM_W'(1));
        last   = (DIM_W'(o_row_e) == rows - DIM_W'(1))
              && (DIM_W'(o_col_e) == cols - DIM_W'(1));

        if (emit) begin
            if (DIM_W'(o_col_e) + DIM_W'(1) >= cols) begin
                n_o_col = '0;
                n_o_row = (DIM_W'(o_row_e) + DIM_W'(1) >= rows) ? '0
                                                                 : o_row_e + ROW_W'(1);
            end else begin
                n_o_col = o_col_e + COL_W'(1);
            end
        end

        // flush that drains everything rewinds both positions
        if (!is_pix && n_pend == '0) begin
            n_in_col = '0;
            n_in_row = '0;
            n_o_col  = '0;
            n_o_row  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_o_col  <= '0;
            r_o_row  <= '0;
            r_pend   <= '0;
        end else if (in_fire) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_o_col  <= n_o_col;
            r_o_row  <= n_o_row;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_pix    <= is_pix;
            r_b_emit   <= emit;
            r_b_border <= border;
            r_b_last   <= last;
            r_b_addr   <= in_col_e;
            r_b_col    <= o_col_e;
            r_b_row    <= o_row_e;
            r_b_sum    <= sum_in;
        end
    end

    // ---------------- line buffer: {row above, current row} per column ----------------
    logic [2*SUM_W-1:0] mem [MAX_COLS];
    logic [2*SUM_W-1:0] r_rd;
    logic [2*SUM_W-1:0] wr_data;
    logic               wr_en;
    t_sum               top, mid;

    assign top     = r_rd[2*SUM_W-1:SUM_W];
    assign mid     = r_rd[SUM_W-1:0];
    assign wr_data = {mid, r_b_sum};
    assign wr_en   = b_go && r_b_pix;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_b_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            // same column written this cycle: forward the new entry
            if (wr_en && r_b_addr == in_col_e) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= mem[in_col_e];
            end
        end
    end

    // ---------------- 3x3 window and edge decision ----------------
    t_sum r_win [9];
    t_sum thr_ext, thr3;
    logic hit;

    always_comb begin
        thr_ext = t_sum'({{(SUM_W-THR_W){r_thr[THR_W-1]}}, r_thr});
        thr3    = (thr_ext <<< 1) + thr_ext;
        // window after the shift: centre is old w5, new column is top/mid/sum
        hit = r_b_pix && !r_b_border && (r_win[5] >= thr3)
           && (crosses(r_win[2], r_win[8]) || crosses(r_win[4], mid)
            || crosses(r_win[1], r_b_sum)  || crosses(r_win[7], top));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (wr_en) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_b_sum;
        end
    end

    // ---------------- result register ----------------
    logic [EDGE_W-1:0] r_edge;
    logic [POS_W-1:0]  r_orow, r_ocol;
    logic              r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_go && r_b_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b_emit) begin
            r_edge  <= hit ? EDGE_ON : EDGE_OFF;
            r_orow  <= POS_W'(r_b_row);
            r_ocol  <= POS_W'(r_b_col);
            r_olast <= r_b_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.edge_value = r_edge;
    assign o_out.out_row    = r_orow;
    assign o_out.out_col    = r_ocol;
    assign o_out.frame_last = r_olast;

endmodule

/* src/zced_checker.sv */
// Port-level checks for the zero crossing edge detector, bound to the top level.
// Depends on zced_pkg and zero_crossing_edge_detector.
module zced_checker import zced_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [EDGE_W-1:0] i_edge_value,
    input logic [POS_W-1:0]  i_out_row,
    input logic [POS_W-1:0]  i_out_col,
    input logic              i_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_edge_value)
            && $stable(i_out_row) && $stable(i_out_col) && $stable(i_frame_last))
        else $error("stalled result changed");

    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_edge_value == EDGE_ON) || (i_edge_value == EDGE_OFF))
        else $error("edge value not 0 or 255");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_row == '0) || (i_out_col == '0)) |-> i_edge_value == EDGE_OFF)
        else $error("edge reported on top or left border");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request blocked while result register empty");

endmodule

bind zero_crossing_edge_detector zced_checker u_zced_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_edge_value (o_out.edge_value),
    .i_out_row    (o_out.out_row),
    .i_out_col    (o_out.out_col),
    .i_frame_last (o_out.frame_last)
);
